// ===== hw/rtl/cnms_pkg.sv =====
package cnms_pkg;

    localparam int GRAD_W = 16;
    localparam int MAG_W  = 15;
    // |grad| reaches 2^15, one bit more than a magnitude
    localparam int ABS_W  = GRAD_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int PA_W   = ABS_W + MAG_W;
    localparam int DIFF_W = MAG_W + 2;
    localparam int PB_W   = DIFF_W + MAG_W + 1;
    localparam int SUM_W  = PB_W + 1;

    typedef logic signed [GRAD_W-1:0] t_grad;
    typedef logic        [MAG_W-1:0]  t_mag;
    typedef logic        [ABS_W-1:0]  t_abs;

    typedef enum logic [1:0] {
        CLS_BORDER = 2'd0,
        CLS_NONE   = 2'd1,
        CLS_EDGE   = 2'd2
    } t_edge_class;

    // one pixel with its 3x3 magnitude window
    typedef struct packed {
        logic  at_border;
        t_grad grad_x;
        t_grad grad_y;
        t_mag  mag_center;
        t_mag  mag_left;
        t_mag  mag_right;
        t_mag  mag_up;
        t_mag  mag_down;
        t_mag  mag_up_left;
        t_mag  mag_up_right;
        t_mag  mag_down_left;
        t_mag  mag_down_right;
    } t_pix;

    // neighbors picked along the gradient, plus early decisions
    typedef struct packed {
        logic border;
        logic zero;
        t_mag mag;
        t_abs minor;
        t_mag diag_a;
        t_mag axial_a;
        t_mag diag_b;
        t_mag axial_b;
    } t_sel;

    // registered products for both sides
    typedef struct packed {
        logic                     border;
        logic                     zero;
        logic        [SQ_W-1:0]   sq;
        logic        [PA_W-1:0]   pa_a;
        logic signed [PB_W-1:0]   pb_a;
        logic        [PA_W-1:0]   pa_b;
        logic signed [PB_W-1:0]   pb_b;
    } t_prod;

endpackage

// ===== hw/rtl/cnms_if.sv =====
interface cnms_pix_if;
    import cnms_pkg::*;

    logic  valid;
    logic  ready;
    logic  at_border;
    t_grad grad_x;
    t_grad grad_y;
    t_mag  mag_center;
    t_mag  mag_left;
    t_mag  mag_right;
    t_mag  mag_up;
    t_mag  mag_down;
    t_mag  mag_up_left;
    t_mag  mag_up_right;
    t_mag  mag_down_left;
    t_mag  mag_down_right;

    modport source (
        output valid, at_border, grad_x, grad_y, mag_center, mag_left, mag_right,
               mag_up, mag_down, mag_up_left, mag_up_right, mag_down_left,
               mag_down_right,
        input  ready
    );
    modport sink (
        input  valid, at_border, grad_x, grad_y, mag_center, mag_left, mag_right,
               mag_up, mag_down, mag_up_left, mag_up_right, mag_down_left,
               mag_down_right,
        output ready
    );
endinterface

interface cnms_cls_if;
    import cnms_pkg::*;

    logic        valid;
    logic        ready;
    t_edge_class edge_class;

    modport source (output valid, edge_class, input ready);
    modport sink (input valid, edge_class, output ready);
endinterface

// ===== hw/rtl/canny_nonmax_suppression.sv =====
// Canny non-maximum suppression, one pixel per transaction. Each input
// transaction carries the gradient components of a pixel and the 3x3 window
// of gradient magnitudes around it; each yields exactly one output
// transaction with edge_class: border (border flag wins over everything),
// none (zero magnitude or suppressed), or edge (center is at least both
// values interpolated along the gradient direction). The interpolation is
// exact: mag*mag >= a*diag + (mag-a)*axial with a = |minor component|, so no
// rounding enters the decision. Rate: one pixel per clock while the output is
// ready. The pipeline is four registers deep: input register, neighbor
// selection, a bank of five parallel multipliers, then the final add and signed
// compare. Stalls on the output back up through the four stages; any empty
// stage is filled, so bubbles collapse.
module canny_nonmax_suppression (
    input logic        i_clk,
    input logic        i_rst_n,
    cnms_pix_if.sink   i_pix,
    cnms_cls_if.source o_cls
);
    import cnms_pkg::*;

    // stage valid bits
    logic r_v1, r_v2, r_v3, r_v4;
    // stage advance enables
    logic n_adv1, n_adv2, n_adv3, n_adv4;

    t_pix        r_pix;
    t_pix        n_pix;
    t_sel        n_sel;
    t_sel        r_sel;
    t_prod       n_prod;
    t_prod       r_prod;
    t_edge_class n_cls;
    t_edge_class r_cls;

    // a stage loads when it is empty or its content moves on
    assign n_adv4 = !r_v4 || o_cls.ready;
    assign n_adv3 = !r_v3 || n_adv4;
    assign n_adv2 = !r_v2 || n_adv3;
    assign n_adv1 = !r_v1 || n_adv2;

    assign i_pix.ready      = n_adv1;
    assign o_cls.valid      = r_v4;
    assign o_cls.edge_class = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (n_adv1) r_v1 <= i_pix.valid;
            if (n_adv2) r_v2 <= r_v1;
            if (n_adv3) r_v3 <= r_v2;
            if (n_adv4) r_v4 <= r_v3;
        end
    end

    // ---- stage 1: capture the window
    always_comb begin
        n_pix.at_border      = i_pix.at_border;
        n_pix.grad_x         = i_pix.grad_x;
        n_pix.grad_y         = i_pix.grad_y;
        n_pix.mag_center     = i_pix.mag_center;
        n_pix.mag_left       = i_pix.mag_left;
        n_pix.mag_right      = i_pix.mag_right;
        n_pix.mag_up         = i_pix.mag_up;
        n_pix.mag_down       = i_pix.mag_down;
        n_pix.mag_up_left    = i_pix.mag_up_left;
        n_pix.mag_up_right   = i_pix.mag_up_right;
        n_pix.mag_down_left  = i_pix.mag_down_left;
        n_pix.mag_down_right = i_pix.mag_down_right;
    end

    always_ff @(posedge i_clk) begin
        if (n_adv1 && i_pix.valid) r_pix <= n_pix;
    end

    // ---- stage 2: pick the dominant axis and the four neighbors
    cnms_select u_select (
        .i_pix (r_pix),
        .o_sel (n_sel)
    );

    always_ff @(posedge i_clk) begin
        if (n_adv2 && r_v1) r_sel <= n_sel;
    end

    // ---- stage 3: products for both sides; (mag - a) may go negative
    logic signed [DIFF_W-1:0] n_diff;
    assign n_diff = $signed({2'b00, r_sel.mag}) - $signed({1'b0, r_sel.minor});

    always_comb begin
        n_prod.border = r_sel.border;
        n_prod.zero   = r_sel.zero;
        n_prod.sq     = SQ_W'(r_sel.mag) * SQ_W'(r_sel.mag);
        n_prod.pa_a   = PA_W'(r_sel.minor) * PA_W'(r_sel.diag_a);
        n_prod.pa_b   = PA_W'(r_sel.minor) * PA_W'(r_sel.diag_b);
        n_prod.pb_a   = PB_W'(n_diff) * PB_W'($signed({1'b0, r_sel.axial_a}));
        n_prod.pb_b   = PB_W'(n_diff) * PB_W'($signed({1'b0, r_sel.axial_b}));
    end

    always_ff @(posedge i_clk) begin
        if (n_adv3 && r_v2) r_prod <= n_prod;
    end

    // ---- stage 4: sum, compare against mag squared, classify
    logic signed [SUM_W-1:0] n_lhs;
    logic signed [SUM_W-1:0] n_rhs_a;
    logic signed [SUM_W-1:0] n_rhs_b;
    logic                    n_keep;

    assign n_lhs   = $signed({{(SUM_W-SQ_W){1'b0}}, r_prod.sq});
    assign n_rhs_a = $signed({{(SUM_W-PA_W){1'b0}}, r_prod.pa_a})
                   + $signed({r_prod.pb_a[PB_W-1], r_prod.pb_a});
    assign n_rhs_b = $signed({{(SUM_W-PA_W){1'b0}}, r_prod.pa_b})
                   + $signed({r_prod.pb_b[PB_W-1], r_prod.pb_b});
    assign n_keep  = (n_lhs >= n_rhs_a) && (n_lhs >= n_rhs_b);

    always_comb begin
        priority if (r_prod.border) begin
            n_cls = CLS_BORDER;
        end else if (r_prod.zero || !n_keep) begin
            n_cls = CLS_NONE;
        end else begin
            n_cls = CLS_EDGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv4 && r_v3) r_cls <= n_cls;
    end

    // ---- checks
    // input can only stall when every stage is full and the output is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && !o_cls.ready))
        else $error("input stalled with a free pipeline stage");

    // an empty output stage always takes the item behind it
    a_fill_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_v4) |=> r_v4)
        else $error("output stage failed to load");

    // output drains when nothing is behind it
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cls.valid && o_cls.ready && !r_v3) |=> !o_cls.valid)
        else $error("output transaction repeated");

endmodule

// ===== hw/rtl/cnms_select.sv =====
module cnms_select (
    input  cnms_pkg::t_pix i_pix,
    output cnms_pkg::t_sel o_sel
);
    import cnms_pkg::*;

    t_abs abs_x;
    t_abs abs_y;
    logic same_sign;
    logic vertical;

    // 16-bit unsigned negate keeps -32768 correct as 32768
    assign abs_x = i_pix.grad_x[GRAD_W-1] ? t_abs'(-i_pix.grad_x) : t_abs'(i_pix.grad_x);
    assign abs_y = i_pix.grad_y[GRAD_W-1] ? t_abs'(-i_pix.grad_y) : t_abs'(i_pix.grad_y);

    assign same_sign = (i_pix.grad_x > 0 && i_pix.grad_y > 0)
                    || (i_pix.grad_x < 0 && i_pix.grad_y < 0);
    assign vertical  = abs_y > abs_x;

    always_comb begin
        o_sel.border = i_pix.at_border;
        o_sel.zero   = (i_pix.mag_center == '0);
        o_sel.mag    = i_pix.mag_center;
        if (vertical) begin
            o_sel.minor   = abs_x;
            o_sel.axial_a = i_pix.mag_up;
            o_sel.axial_b = i_pix.mag_down;
            o_sel.diag_a  = same_sign ? i_pix.mag_up_left    : i_pix.mag_up_right;
            o_sel.diag_b  = same_sign ? i_pix.mag_down_right : i_pix.mag_down_left;
        end else begin
            o_sel.minor   = abs_y;
            o_sel.axial_a = i_pix.mag_right;
            o_sel.axial_b = i_pix.mag_left;
            o_sel.diag_a  = same_sign ? i_pix.mag_down_right : i_pix.mag_up_right;
            o_sel.diag_b  = same_sign ? i_pix.mag_up_left    : i_pix.mag_down_left;
        end
    end

endmodule
